FILE: src/msadpcm_pkg.sv
// ----------------------------------------------------------------------------
// MS-ADPCM stereo decoder package
// Shared types, stream layout constants and decode tables.
// ----------------------------------------------------------------------------
package msadpcm_pkg;

  // Item kind, carried on the slave tuser bit
  typedef enum logic {
    CMD_HEADER = 1'b0,
    CMD_DATA   = 1'b1
  } cmd_e;

  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [15:0]        STEP_MIN   = 16'd16;
  localparam logic [15:0]        STEP_RESET = 16'd16;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

  // Header load for one channel
  typedef struct packed {
    logic [2:0]         pred;
    logic [15:0]        delta;
    logic signed [15:0] newer;
    logic signed [15:0] older;
  } chan_hdr_t;

  // Predictor coefficient on the newer history sample
  function automatic logic signed [10:0] coef_newer(input logic [2:0] idx);
    logic signed [10:0] c;
    unique case (idx)
      3'd0:    c = 11'sd256;
      3'd1:    c = 11'sd512;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd192;
      3'd4:    c = 11'sd240;
      3'd5:    c = 11'sd460;
      3'd6:    c = 11'sd392;
      default: c = 11'sd0;
    endcase
    return c;
  endfunction

  // Predictor coefficient on the older history sample
  function automatic logic signed [10:0] coef_older(input logic [2:0] idx);
    logic signed [10:0] c;
    unique case (idx)
      3'd1:    c = -11'sd256;
      3'd3:    c = 11'sd64;
      3'd5:    c = -11'sd208;
      3'd6:    c = -11'sd232;
      default: c = 11'sd0;
    endcase
    return c;
  endfunction

  // Step size adaptation factor, in 1/256 units
  function automatic logic [9:0] adapt_factor(input logic [3:0] code);
    logic [9:0] a;
    unique case (code)
      4'd4, 4'd12: a = 10'd307;
      4'd5, 4'd11: a = 10'd409;
      4'd6, 4'd10: a = 10'd512;
      4'd7, 4'd9:  a = 10'd614;
      4'd8:        a = 10'd768;
      default:     a = 10'd230;
    endcase
    return a;
  endfunction

endpackage

FILE: src/ms_adpcm_stereo_decoder.sv
// ----------------------------------------------------------------------------
// MS-ADPCM stereo decoder
// Header items load both channels and replay their history as two frames;
// data items decode one byte (two nibbles) into one stereo frame.
// ----------------------------------------------------------------------------
// Path: input register, decode, output register.
// Throughput: one data item per cycle while the output is not stalled; a
// header item holds off the next item, since its two frames share the single
// output register.
// Reset: all valid flags clear; predictors 0, step sizes 16, history 0.
module ms_adpcm_stereo_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] data_byte, [10:8] pred_left, [13:11] pred_right,
  // [29:14] delta_left, [45:30] delta_right, [61:46] newer_left,
  // [77:62] newer_right, [93:78] older_left, [109:94] older_right, rest zero
  input  logic [111:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // [0] cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
  output logic         m_axis_tlast    // last_of_run
);

  logic                                    in_vld_q;
  msadpcm_pkg::cmd_e                       in_cmd_q;
  logic [msadpcm_pkg::IN_TDATA_W-1:0]      in_data_q;

  logic                                    out_vld_q, out_vld_d;
  logic [msadpcm_pkg::OUT_TDATA_W-1:0]     out_data_q, out_data_d;
  logic                                    out_last_q, out_last_d;
  logic                                    pend_vld_q, pend_vld_d;
  logic [msadpcm_pkg::OUT_TDATA_W-1:0]     pend_data_q, pend_data_d;

  logic                   out_free, fire, is_hdr, is_data;
  msadpcm_pkg::chan_hdr_t hdr_l, hdr_r;
  logic signed [15:0]     smp_l, smp_r;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && out_free && !pend_vld_q;
  assign s_axis_tready = !in_vld_q || fire;
  assign is_hdr        = fire && (in_cmd_q == msadpcm_pkg::CMD_HEADER);
  assign is_data       = fire && (in_cmd_q == msadpcm_pkg::CMD_DATA);

  assign hdr_l.pred  = in_data_q[10:8];
  assign hdr_l.delta = in_data_q[29:14];
  assign hdr_l.newer = in_data_q[61:46];
  assign hdr_l.older = in_data_q[93:78];
  assign hdr_r.pred  = in_data_q[13:11];
  assign hdr_r.delta = in_data_q[45:30];
  assign hdr_r.newer = in_data_q[77:62];
  assign hdr_r.older = in_data_q[109:94];

  msadpcm_chan u_chan_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (is_hdr),
    .hdr_i    (hdr_l),
    .step_i   (is_data),
    .nibble_i (in_data_q[7:4]),
    .sample_o (smp_l)
  );

  msadpcm_chan u_chan_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (is_hdr),
    .hdr_i    (hdr_r),
    .step_i   (is_data),
    .nibble_i (in_data_q[3:0]),
    .sample_o (smp_r)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= msadpcm_pkg::cmd_e'(s_axis_tuser);
      in_data_q <= s_axis_tdata;
    end
  end

  // Output register; a header parks its newer frame until the older one goes
  always_comb begin
    out_vld_d   = out_vld_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    pend_vld_d  = pend_vld_q;
    pend_data_d = pend_data_q;
    if (out_free) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_data_d = pend_data_q;
        out_last_d = 1'b1;
        pend_vld_d = 1'b0;
      end else if (is_hdr) begin
        out_vld_d   = 1'b1;
        out_data_d  = {hdr_r.older, hdr_l.older};
        out_last_d  = 1'b0;
        pend_vld_d  = 1'b1;
        pend_data_d = {hdr_r.newer, hdr_l.newer};
      end else if (is_data) begin
        out_vld_d  = 1'b1;
        out_data_d = {smp_r, smp_l};
        out_last_d = 1'b1;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
    pend_data_q <= pend_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: src/msadpcm_chan.sv
// ----------------------------------------------------------------------------
// MS-ADPCM channel decoder
// Holds one channel's predictor, step size and history, and decodes one
// nibble per step.
// ----------------------------------------------------------------------------
module msadpcm_chan (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,    // header load
  input  msadpcm_pkg::chan_hdr_t hdr_i,
  input  logic                   step_i,    // decode nibble_i, update state
  input  logic [3:0]             nibble_i,
  output logic signed [15:0]     sample_o
);

  logic [2:0]         pred_q, pred_d;
  logic [15:0]        delta_q, delta_d;
  logic signed [15:0] newer_q, newer_d;
  logic signed [15:0] older_q, older_d;

  logic signed [10:0] c0, c1;
  logic signed [27:0] prod0, prod1, pred_sum;
  logic signed [19:0] pred_val;
  logic signed [3:0]  nib;
  logic signed [16:0] delta_s;
  logic signed [20:0] nib_delta;
  logic signed [21:0] raw;
  logic [25:0]        adapt_prod;
  logic [15:0]        delta_new;

  always_comb begin
    c0        = msadpcm_pkg::coef_newer(pred_q);
    c1        = msadpcm_pkg::coef_older(pred_q);
    prod0     = 28'(c0) * 28'(newer_q);
    prod1     = 28'(c1) * 28'(older_q);
    pred_sum  = prod0 + prod1;
    // arithmetic shift gives floor division by 256
    pred_val  = pred_sum[27:8];
    nib       = $signed(nibble_i);
    delta_s   = $signed({1'b0, delta_q});
    nib_delta = 21'(nib) * 21'(delta_s);
    raw       = 22'(pred_val) + 22'(nib_delta);
    if (raw > 22'(msadpcm_pkg::SAMPLE_MAX)) begin
      sample_o = msadpcm_pkg::SAMPLE_MAX;
    end else if (raw < 22'(msadpcm_pkg::SAMPLE_MIN)) begin
      sample_o = msadpcm_pkg::SAMPLE_MIN;
    end else begin
      sample_o = raw[15:0];
    end

    // adapted step wraps to 16 bits before the floor is applied
    adapt_prod = 26'(msadpcm_pkg::adapt_factor(nibble_i)) * 26'(delta_q);
    delta_new  = adapt_prod[23:8];
    if (delta_new < msadpcm_pkg::STEP_MIN) begin
      delta_new = msadpcm_pkg::STEP_MIN;
    end
  end

  always_comb begin
    pred_d  = pred_q;
    delta_d = delta_q;
    newer_d = newer_q;
    older_d = older_q;
    if (load_i) begin
      pred_d  = hdr_i.pred;
      delta_d = hdr_i.delta;
      newer_d = hdr_i.newer;
      older_d = hdr_i.older;
    end else if (step_i) begin
      delta_d = delta_new;
      newer_d = sample_o;
      older_d = newer_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q  <= '0;
      delta_q <= msadpcm_pkg::STEP_RESET;
      newer_q <= '0;
      older_q <= '0;
    end else begin
      pred_q  <= pred_d;
      delta_q <= delta_d;
      newer_q <= newer_d;
      older_q <= older_d;
    end
  end

endmodule
